[rtl/ggt_pkg.sv]
// Shared types, constants and the GF(2^128) digit step for the GHASH tag unit.
// Used by ggt_front, ggt_queue, ggt_back and gcm_ghash_tag_unit.
package ggt_pkg;

  localparam int BLK_W        = 128;
  localparam int HALF_W       = 64;
  localparam int NBYTES_W     = 5;
  localparam int BLK_BYTES    = BLK_W / 8;
  localparam int DIGIT_W      = 32;
  localparam int STEPS        = BLK_W / DIGIT_W;
  localparam int STEP_W       = $clog2(STEPS);
  localparam int CNT_W        = 61;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_W        = 64;
  localparam int IN_TDATA_W   = 136;
  localparam int OUT_TDATA_W  = 128;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] RED_POLY  = 8'he1;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef enum logic [1:0] {
    ACT_AAD    = 2'd0,
    ACT_CT     = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_HI  = 2'd0,
    CFG_KEY_LO  = 2'd1,
    CFG_MASK_HI = 2'd2,
    CFG_MASK_LO = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    BK_IDLE,
    BK_BUSY
  } back_state_t;

  typedef struct packed {
    action_t               act;
    logic [BLK_W-1:0]      blk;
    logic [NBYTES_W-1:0]   nbytes;
  } q_item_t;

  typedef struct packed {
    logic pop;
    logic out_load;
  } back_stat_t;

  typedef struct packed {
    logic [BLK_W-1:0] z;
    logic [BLK_W-1:0] v;
  } gf_pair_t;

  // One digit of the bit-serial GCM multiply: the first operand bit of the
  // digit sits in the top bit; v walks from H by one power of x per bit.
  function automatic gf_pair_t gf_step(input logic [BLK_W-1:0] z_in,
                                       input logic [BLK_W-1:0] v_in,
                                       input logic [DIGIT_W-1:0] digit);
    gf_pair_t         r;
    logic [BLK_W-1:0] z;
    logic [BLK_W-1:0] v;
    logic             lsb;
    z = z_in;
    v = v_in;
    for (int i = 0; i < DIGIT_W; i++) begin
      if (digit[DIGIT_W-1-i]) begin
        z = z ^ v;
      end
      lsb = v[0];
      v = v >> 1;
      if (lsb) begin
        v[BLK_W-1 -: 8] = v[BLK_W-1 -: 8] ^ RED_POLY;
      end
    end
    r.z = z;
    r.v = v;
    return r;
  endfunction

endpackage

[rtl/ggt_front.sv]
// Front end of the GHASH tag unit: takes input transfers, drops no-op items,
// zero-pads partial blocks and pushes work into the queue. Uses ggt_pkg.
module ggt_front (
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ggt_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // block_hi, block_lo, valid_bytes
  input  logic [1:0]                     s_axis_tuser,  // action
  input  logic                           q_full,
  output logic                           q_push,
  output ggt_pkg::q_item_t               q_item
);
  import ggt_pkg::*;

  logic [HALF_W-1:0]   blk_hi;
  logic [HALF_W-1:0]   blk_lo;
  logic [NBYTES_W-1:0] nraw;
  logic [NBYTES_W-1:0] nsat;
  logic [BLK_W-1:0]    keep_mask;
  logic                keep;

  assign blk_hi = s_axis_tdata[HALF_W-1:0];
  assign blk_lo = s_axis_tdata[2*HALF_W-1:HALF_W];
  assign nraw   = s_axis_tdata[2*HALF_W +: NBYTES_W];
  assign nsat   = (nraw > NBYTES_W'(BLK_BYTES)) ? NBYTES_W'(BLK_BYTES) : nraw;

  // byte 0 is the top byte of the block
  always_comb begin
    keep_mask = '0;
    for (int k = 0; k < BLK_BYTES; k++) begin
      if (NBYTES_W'(k) < nsat) begin
        keep_mask[BLK_W-1-8*k -: 8] = BYTE_MASK;
      end
    end
  end

  always_comb begin
    unique case (s_axis_tuser)
      ACT_AAD, ACT_CT: keep = (nraw != '0);
      ACT_FINISH:      keep = 1'b1;
      default:         keep = 1'b0;
    endcase
  end

  // unused codes and empty blocks are taken and dropped here
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full && keep;
  assign q_item        = {action_t'(s_axis_tuser), {blk_hi, blk_lo} & keep_mask, nsat};

endmodule

[rtl/ggt_queue.sv]
// Small register queue between the front end and the hash engine.
// Uses ggt_pkg for the item type.
module ggt_queue #(
  parameter int DEPTH = ggt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ggt_pkg::q_item_t push_item,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output ggt_pkg::q_item_t head_item
);
  import ggt_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  q_item_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;

  assign full       = (fill == FILL_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[rtl/ggt_back.sv]
// Hash engine of the GHASH tag unit: configuration registers, byte counts,
// accumulator, digit-serial GF(2^128) multiply and the tag output register.
module ggt_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ggt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ggt_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            q_valid,
  input  ggt_pkg::q_item_t                q_item,
  output ggt_pkg::back_stat_t             stat,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ggt_pkg::OUT_TDATA_W-1:0] m_axis_tdata  // tag_hi, tag_lo
);
  import ggt_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

  logic [HALF_W-1:0] key_hi, key_lo, mask_hi, mask_lo;
  logic [BLK_W-1:0]  acc, acc_next;
  logic [BLK_W-1:0]  x, z, v;
  logic [STEP_W-1:0] step;
  action_t           kind;
  logic [CNT_W-1:0]  aad_cnt, ct_cnt;
  back_state_t       state, state_next;
  gf_pair_t          gf;
  logic [BLK_W-1:0]  len_blk, tag;
  logic              last, stall_out, done, pop, out_load, tvalid_next;

  assign gf        = gf_step(z, v, x[BLK_W-1 -: DIGIT_W]);
  assign last      = (state == BK_BUSY) && (step == STEP_LAST);
  assign stall_out = last && (kind == ACT_FINISH) && m_axis_tvalid && !m_axis_tready;
  assign done      = last && !stall_out;
  assign pop       = q_valid && ((state == BK_IDLE) || done);
  assign out_load  = done && (kind == ACT_FINISH);
  assign len_blk   = {aad_cnt, 3'b000, ct_cnt, 3'b000};
  assign tag       = gf.z ^ {mask_hi, mask_lo};
  assign tvalid_next = out_load || (m_axis_tvalid && !m_axis_tready);

  always_comb begin
    if (done) begin
      acc_next = (kind == ACT_FINISH) ? '0 : gf.z;
    end else begin
      acc_next = acc;
    end
  end

  assign stat = {pop, out_load};

  // next state
  always_comb begin
    unique case (state)
      BK_IDLE: state_next = pop ? BK_BUSY : BK_IDLE;
      BK_BUSY: state_next = (done && !pop) ? BK_IDLE : BK_BUSY;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      step          <= '0;
      acc           <= '0;
      aad_cnt       <= '0;
      ct_cnt        <= '0;
      m_axis_tvalid <= 1'b0;
      key_hi        <= '0;
      key_lo        <= '0;
      mask_hi       <= '0;
      mask_lo       <= '0;
    end else begin
      state         <= state_next;
      acc           <= acc_next;
      m_axis_tvalid <= tvalid_next;
      if (pop) begin
        step <= '0;
        unique case (q_item.act)
          ACT_AAD: aad_cnt <= aad_cnt + CNT_W'(q_item.nbytes);
          ACT_CT:  ct_cnt  <= ct_cnt + CNT_W'(q_item.nbytes);
          default: begin
            aad_cnt <= '0;
            ct_cnt  <= '0;
          end
        endcase
      end else if ((state == BK_BUSY) && !stall_out) begin
        step <= step + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_KEY_HI:  key_hi  <= cfg_data;
          CFG_KEY_LO:  key_lo  <= cfg_data;
          CFG_MASK_HI: mask_hi <= cfg_data;
          CFG_MASK_LO: mask_lo <= cfg_data;
          default:     key_hi  <= key_hi;
        endcase
      end
    end
  end

  // multiply datapath; the accumulator forwards straight into the next block
  always_ff @(posedge clk) begin
    if (pop) begin
      x    <= acc_next ^ ((q_item.act == ACT_FINISH) ? len_blk : q_item.blk);
      z    <= '0;
      v    <= {key_hi, key_lo};
      kind <= q_item.act;
    end else if ((state == BK_BUSY) && !stall_out) begin
      x <= x << DIGIT_W;
      z <= gf.z;
      v <= gf.v;
    end
    if (out_load) begin
      m_axis_tdata <= {tag[HALF_W-1:0], tag[BLK_W-1:HALF_W]};
    end
  end

endmodule

[rtl/gcm_ghash_tag_unit.sv]
// GCM tag unit: hashes AAD and ciphertext blocks with GHASH under the key H
// and, on a finish item, hashes the length block and returns the tag masked
// with E(K,J0); the accumulator and both byte counts then clear. An input
// transfer is taken every cycle while the QUEUE_DEPTH-entry work queue has
// room. The hash engine multiplies 32 operand bits per cycle in GF(2^128),
// except while a finished tag waits for an output still holding the last one,
// and takes its next item from the queue as it finishes the one before.
// Empty blocks and unused action codes are taken and cost no engine time.
module gcm_ghash_tag_unit #(
  parameter int QUEUE_DEPTH = ggt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ggt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ggt_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ggt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // block_hi, block_lo, valid_bytes
  input  logic [1:0]                      s_axis_tuser,  // action
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ggt_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // tag_hi, tag_lo
);
  import ggt_pkg::*;

  q_item_t    push_item, head_item;
  logic       q_full;
  logic       q_push;
  logic       head_valid;
  back_stat_t bs;

  ggt_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  ggt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .pop        (bs.pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ggt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (head_valid),
    .q_item        (head_item),
    .stat          (bs),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full work queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    bs.pop |-> head_valid)
    else $error("hash engine popped an empty queue");

  a_no_tag_overwrite: assert property (@(posedge clk) disable iff (rst)
    bs.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("tag loaded over a result still waiting");

  a_tag_follows_load: assert property (@(posedge clk) disable iff (rst)
    bs.out_load |=> m_axis_tvalid)
    else $error("loaded tag not presented");

endmodule

[sim/tb_gcm_ghash_tag_unit.sv]
// Self-checking testbench for gcm_ghash_tag_unit: GHASH over AAD and ciphertext
// blocks, length block and tag mask, checked against an in-bench GF(2^128) model.
// Depends on ggt_pkg and the RTL of the unit only.
`timescale 1ns / 1ps

module tb_gcm_ghash_tag_unit;
  import ggt_pkg::*;

  localparam logic [1:0]   ACT_UNUSED   = 2'd3;
  localparam logic [127:0] REDUCE_TERM  = {RED_POLY, 120'b0};
  localparam int           IDLE_PCT     = 23;
  localparam int           DRAIN_CYCLES = 40;
  localparam int           STALL_LIMIT  = 5000;

  typedef struct {
    logic [1:0]  act;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nb;
  } block_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_KEY_HI;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // block_hi, block_lo, valid_bytes
  logic [1:0]             s_axis_tuser = '0;  // action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;       // tag_hi, tag_lo

  gcm_ghash_tag_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Model state and settings
  logic [127:0] hash_key;
  logic [127:0] out_mask;
  logic [127:0] ghash_state;
  logic [60:0]  aad_bytes;
  logic [60:0]  ct_bytes;

  block_item_t  send_queue[$];
  block_item_t  nxt;
  logic [127:0] tags_due[$];

  bit steady = 1'b0;
  int stim_items = 0;
  int blocks_hashed = 0;
  int ignored_items = 0;
  int tags_checked = 0;
  int key_settings = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  // GF(2^128) product in GCM bit order: x[127] is the first coefficient.
  function automatic logic [127:0] gf_mult(input logic [127:0] x, input logic [127:0] h);
    logic [127:0] z;
    logic [127:0] v;
    z = '0;
    v = h;
    for (int i = 127; i >= 0; i--) begin
      if (x[i]) begin
        z = z ^ v;
      end
      if (v[0]) begin
        v = (v >> 1) ^ REDUCE_TERM;
      end else begin
        v = v >> 1;
      end
    end
    return z;
  endfunction

  task automatic absorb_transfer(input logic [1:0] act, input logic [63:0] hi,
                                 input logic [63:0] lo, input logic [4:0] nb);
    logic [4:0]   n;
    logic [127:0] blk;
    if (act == ACT_FINISH) begin
      ghash_state = gf_mult(ghash_state ^ {aad_bytes, 3'b0, ct_bytes, 3'b0}, hash_key);
      tags_due.push_back(ghash_state ^ out_mask);
      ghash_state = '0;
      aad_bytes = '0;
      ct_bytes = '0;
    end else if (act == ACT_UNUSED || nb == 5'd0) begin
      ignored_items++;
    end else begin
      n = (nb > 5'd16) ? 5'd16 : nb;
      blk = {hi, lo} & (~128'b0 << (8 * (16 - n)));
      ghash_state = gf_mult(ghash_state ^ blk, hash_key);
      if (act == ACT_AAD) begin
        aad_bytes = aad_bytes + n;
      end else begin
        ct_bytes = ct_bytes + n;
      end
      blocks_hashed++;
    end
  endtask

  // Driver: present the next pending transfer, idling at random
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = send_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.act;
        s_axis_tdata  <= {3'b0, nxt.nb, nxt.lo, nxt.hi};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on input transfers, check tags on output transfers
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_transfer(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[127:64],
                        s_axis_tdata[132:128]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (tags_due.size() == 0) begin
          $error("unexpected tag %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = tags_due.pop_front();
          tags_checked++;
          if (m_axis_tdata[63:0] !== want[127:64]) begin
            $error("tag_hi: expected %h, got %h", want[127:64], m_axis_tdata[63:0]);
            mismatches++;
          end
          if (m_axis_tdata[127:64] !== want[63:0]) begin
            $error("tag_lo: expected %h, got %h", want[63:0], m_axis_tdata[127:64]);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("gcm_ghash_tag_unit test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_item(input logic [1:0] act, input logic [63:0] hi,
                            input logic [63:0] lo, input logic [4:0] nb);
    block_item_t it;
    it.act = act;
    it.hi = hi;
    it.lo = lo;
    it.nb = nb;
    send_queue.push_back(it);
    if (act == ACT_FINISH || (act != ACT_UNUSED && nb != 5'd0)) begin
      stim_items++;
    end
  endtask

  task automatic queue_noise();
    case ($urandom_range(3))
      0: queue_item(ACT_UNUSED, rand64(), rand64(), 5'($urandom_range(31)));
      1: queue_item(2'($urandom_range(1)), rand64(), rand64(), 5'd0);
      2: queue_item(2'($urandom_range(1)), rand64(), rand64(), 5'($urandom_range(17, 31)));
      default: queue_item(ACT_AAD, rand64(), rand64(), 5'($urandom_range(1, 16)));
    endcase
  endtask

  // One message: AAD blocks, ciphertext blocks, partial last blocks, then finish
  task automatic queue_message();
    int na;
    int nc;
    na = $urandom_range(0, 4);
    nc = $urandom_range(0, 6);
    for (int i = 0; i < na; i++) begin
      queue_item(ACT_AAD, rand64(), rand64(),
                 (i == na - 1) ? 5'($urandom_range(1, 16)) : 5'd16);
    end
    for (int i = 0; i < nc; i++) begin
      if ($urandom_range(11) == 0) begin
        queue_noise();
      end
      queue_item(ACT_CT, rand64(), rand64(),
                 (i == nc - 1) ? 5'($urandom_range(1, 16)) : 5'd16);
    end
    if ($urandom_range(9) == 0) begin
      queue_noise();
    end
    queue_item(ACT_FINISH, rand64(), rand64(), 5'($urandom_range(31)));
  endtask

  // Sample mid-cycle so driver and monitor updates have settled
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (send_queue.size() != 0 || s_axis_tvalid || tags_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_keys(input logic [127:0] h, input logic [127:0] m);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_HI;
    cfg_data  <= h[127:64];
    @(posedge clk);
    cfg_index <= CFG_KEY_LO;
    cfg_data  <= h[63:0];
    @(posedge clk);
    cfg_index <= CFG_MASK_HI;
    cfg_data  <= m[127:64];
    @(posedge clk);
    cfg_index <= CFG_MASK_LO;
    cfg_data  <= m[63:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    hash_key = h;
    out_mask = m;
    key_settings++;
  endtask

  task automatic run_messages(input int target);
    while (stim_items < target) begin
      queue_message();
    end
    wait_drained();
  endtask

  initial begin
    hash_key = '0;
    out_mask = '0;
    ghash_state = '0;
    aad_bytes = '0;
    ct_bytes = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    load_keys({rand64(), rand64()}, {rand64(), rand64()});
    // Directed: empty message, byte-count edges, ignored codes, saturation, order abuse
    queue_item(ACT_FINISH, '0, '0, 5'd0);
    queue_item(ACT_AAD, '1, '1, 5'd16);
    queue_item(ACT_AAD, '1, '1, 5'd1);
    queue_item(ACT_CT, '1, '1, 5'd8);
    queue_item(ACT_CT, '1, '1, 5'd9);
    queue_item(ACT_CT, '0, '0, 5'd16);
    queue_item(ACT_CT, '1, '1, 5'd15);
    queue_item(ACT_FINISH, '1, '1, 5'd31);
    queue_item(ACT_UNUSED, '1, '1, 5'd31);
    queue_item(ACT_AAD, '1, '1, 5'd0);
    queue_item(ACT_AAD, rand64(), rand64(), 5'd7);
    queue_item(ACT_CT, rand64(), rand64(), 5'd31);
    queue_item(ACT_CT, rand64(), rand64(), 5'd17);
    queue_item(ACT_AAD, rand64(), rand64(), 5'd5);
    queue_item(ACT_FINISH, '0, '0, 5'd16);
    queue_item(ACT_CT, rand64(), rand64(), 5'd12);
    queue_item(ACT_UNUSED, '0, '0, 5'd0);
    queue_item(ACT_FINISH, rand64(), rand64(), 5'd0);
    wait_drained();

    // Random messages under a range of key and mask settings
    load_keys('0, '0);
    run_messages(200);
    load_keys('1, '1);
    run_messages(380);
    load_keys({1'b1, 127'b0}, {rand64(), rand64()});
    run_messages(560);
    load_keys({rand64(), rand64()}, {rand64(), rand64()});
    steady = 1'b1;
    run_messages(960);
    steady = 1'b0;
    load_keys({rand64(), rand64()}, {rand64(), rand64()});
    run_messages(1550);

    $display("Hashed %0d blocks and checked %0d tags over %0d key/mask settings;",
             blocks_hashed, tags_checked, key_settings);
    $display("%0d transfers carried unused codes or empty blocks.", ignored_items);
    if (mismatches == 0) begin
      $display("gcm_ghash_tag_unit test passed");
    end else begin
      $display("gcm_ghash_tag_unit test failed");
    end
    $finish;
  end

endmodule
